>>> sv/fia_pkg.sv
package fia_pkg;

  localparam int TS_W      = 64;
  localparam int ELAPSED_W = 32;
  localparam int RATE_W    = 16;
  localparam int WIN_W     = 40;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 6;

  localparam logic [CFG_W-1:0] TPS_RESET = 32'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME_TICKS  = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [TS_W-1:0] timestamp;
  } fia_in_t;

  typedef struct packed {
    logic                 frame_done;
    logic [ELAPSED_W-1:0] elapsed_ticks;
    logic [ELAPSED_W-1:0] average_ticks;
    logic [RATE_W-1:0]    frame_rate;
    logic [COUNT_W-1:0]   sample_count;
  } fia_out_t;

endpackage

>>> sv/fia_ram.sv
module fia_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/frame_interval_averager.sv
// path to out_valid_o: start item S_CALC, S_OUT; frame held back by the lock interval
//   S_CALC, S_LOCK, S_OUT; other frames S_CALC, S_LOCK, S_DEV, S_UPD, S_DIV, S_OUT
// S_DIV, skipped for a frame that leaves the window empty, is the bit-serial restoring
//   divider forming the average, one bit a cycle; one transaction in flight, taken the
//   cycle after the result loads; S_OUT waits while the previous result is stalled
// asynchronous active-low reset resets all registers (ticks per second to TPS_RESET); the interval store is not cleared
module frame_interval_averager import fia_pkg::*; #(
  parameter int SAMPLE_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fia_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fia_out_t             out_data_o
);

  localparam int PTR_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUM_W  = ELAPSED_W + $clog2(SAMPLE_DEPTH);
  localparam int DCNT_W = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_LOCK,
    S_DEV,
    S_UPD,
    S_DIV,
    S_OUT
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     tps_q;
  logic [CFG_W-1:0]     min_q;
  fia_in_t              in_q;
  logic [TS_W-1:0]      last_ts_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [ELAPSED_W-1:0] dev_q;
  logic                 done_q;
  logic                 pass_q;
  logic [PTR_W-1:0]     wp_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SUM_W-1:0]     sum_q;
  logic [ELAPSED_W-1:0] avg_q;
  logic [RATE_W-1:0]    wf_q;
  logic [WIN_W-1:0]     wt_q;
  logic [RATE_W-1:0]    rate_q;
  logic [SUM_W-1:0]     dvd_q;
  logic [CNT_W-1:0]     rem_q;
  logic [DCNT_W-1:0]    dcnt_q;
  logic                 out_valid_q;
  fia_out_t             out_q;

  logic [TS_W-1:0]      diff;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic                 pass;
  logic                 full;
  logic [ELAPSED_W-1:0] rd_data;
  logic                 ram_we;
  logic [WIN_W:0]       wt_sum;
  logic [SUM_W-1:0]     sum_next;
  logic [CNT_W:0]       rem_shift;
  logic                 q_bit;
  logic [CNT_W-1:0]     rem_d;
  logic [SUM_W-1:0]     dvd_d;
  logic [CNT_W+5:0]     cnt_ext;

  assign diff        = in_q.timestamp - last_ts_q;
  assign elapsed_sat = (|diff[TS_W-1:ELAPSED_W]) ? '1 : diff[ELAPSED_W-1:0];
  assign pass        = dev_q < tps_q;
  assign full        = cnt_q == CNT_W'(SAMPLE_DEPTH);
  assign ram_we      = (state_q == S_DEV) && pass;
  assign wt_sum      = {1'b0, wt_q} + (WIN_W + 1)'(elapsed_q);
  assign sum_next    = pass_q ? sum_q + SUM_W'(elapsed_q) : sum_q;

  // restoring divide step: remainder stays below the count
  assign rem_shift = {rem_q, dvd_q[SUM_W-1]};
  assign q_bit     = rem_shift >= {1'b0, cnt_q};
  assign rem_d     = q_bit ? CNT_W'(rem_shift - {1'b0, cnt_q}) : rem_shift[CNT_W-1:0];
  assign dvd_d     = {dvd_q[SUM_W-2:0], q_bit};

  assign cnt_ext   = (CNT_W + 6)'(cnt_q);

  fia_ram #(
    .WIDTH (ELAPSED_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (elapsed_q),
    .raddr_i (wp_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tps_q       <= TPS_RESET;
      min_q       <= '0;
      in_q        <= '0;
      last_ts_q   <= '0;
      elapsed_q   <= '0;
      dev_q       <= '0;
      done_q      <= 1'b0;
      pass_q      <= 1'b0;
      wp_q        <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      wf_q        <= '0;
      wt_q        <= '0;
      rate_q      <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TICKS_PER_SECOND: tps_q <= cfg_data_i;
          REG_MIN_FRAME_TICKS:  min_q <= cfg_data_i;
          default: ;
        endcase
      end

      // in S_OUT the output register load below sets the valid flag itself
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          done_q <= 1'b0;
          if (in_q.kind == KIND_START) begin
            last_ts_q <= in_q.timestamp;
            elapsed_q <= '0;
            state_q   <= S_OUT;
          end else begin
            elapsed_q <= elapsed_sat;
            state_q   <= S_LOCK;
          end
        end
        S_LOCK: begin
          if ((min_q != '0) && (elapsed_q < min_q)) begin
            state_q <= S_OUT;
          end else begin
            last_ts_q <= in_q.timestamp;
            done_q    <= 1'b1;
            dev_q     <= (elapsed_q >= avg_q) ? elapsed_q - avg_q : avg_q - elapsed_q;
            state_q   <= S_DEV;
          end
        end
        S_DEV: begin
          // store read data for the write pointer arrives this cycle
          pass_q <= pass;
          if (pass) begin
            if (full) begin
              sum_q <= sum_q - SUM_W'(rd_data);
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
            wp_q <= (wp_q == PTR_W'(SAMPLE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          end
          if (wf_q != '1) begin
            wf_q <= wf_q + 1'b1;
          end
          wt_q    <= wt_sum[WIN_W] ? '1 : wt_sum[WIN_W-1:0];
          state_q <= S_UPD;
        end
        S_UPD: begin
          sum_q <= sum_next;
          if (wt_q > WIN_W'(tps_q)) begin
            rate_q <= wf_q;
            wf_q   <= '0;
            wt_q   <= '0;
          end
          dvd_q  <= sum_next;
          rem_q  <= '0;
          dcnt_q <= DCNT_W'(SUM_W);
          if (cnt_q == '0) begin
            avg_q   <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          dvd_q  <= dvd_d;
          rem_q  <= rem_d;
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == DCNT_W'(1)) begin
            avg_q   <= dvd_d[ELAPSED_W-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.frame_done    <= done_q;
            out_q.elapsed_ticks <= elapsed_q;
            out_q.average_ticks <= avg_q;
            out_q.frame_rate    <= rate_q;
            out_q.sample_count  <= cnt_ext[COUNT_W-1:0];
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/fia_checker.sv
module fia_checker import fia_pkg::*; #(
  parameter int SAMPLE_DEPTH = 32
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input fia_out_t out_data_o
);

  // a result waiting on the consumer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // the block takes one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in progress");

  // the averaging window never reports more entries than it holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (SAMPLE_DEPTH > 63) || (out_data_o.sample_count <= SAMPLE_DEPTH))
    else $error("sample count beyond window depth");

  // an empty window averages to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.sample_count == '0) |->
      (SAMPLE_DEPTH > 63) || (out_data_o.average_ticks == '0))
    else $error("nonzero average with empty window");

endmodule

bind frame_interval_averager fia_checker #(
  .SAMPLE_DEPTH (SAMPLE_DEPTH)
) u_fia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> tb/frame_interval_averager_tb.sv
module frame_interval_averager_tb;
  import fia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 60;

  typedef enum logic {ROW_EVENT, ROW_CONFIG} row_e;

  typedef struct {
    row_e        what;
    fia_in_t     ev;
    bit          typed;
    fia_out_t    want;
    logic [31:0] tps;
    logic [31:0] mft;
  } dir_row_t;

  typedef struct {
    logic [31:0] tps;
    logic [31:0] mft;
    bit          lock_near;
    int          send_pct;
    int          stall_pct;
    int          events;
    bit          hold;
    bit          pause;
  } phase_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_TICKS_PER_SECOND;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  fia_in_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  fia_out_t             out_data_o;

  frame_interval_averager #(
    .SAMPLE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // timer model state
  logic [CFG_W-1:0]     cur_tps = TPS_RESET;
  logic [CFG_W-1:0]     cur_min = '0;
  logic [TS_W-1:0]      prev_stamp = '0;
  logic [31:0]          ring [DEPTH];
  int                   ring_ptr = 0;
  logic [COUNT_W-1:0]   ring_fill = '0;
  logic [36:0]          ring_total = '0;
  logic [31:0]          mean_ticks = '0;
  logic [RATE_W-1:0]    win_frames = '0;
  logic [WIN_W-1:0]     win_accum = '0;
  logic [RATE_W-1:0]    rate_shown = '0;

  fia_out_t             expected_q[$];
  dir_row_t             dir_rows[$];

  int                   errors = 0;
  int                   cycle_count = 0;
  int                   send_pct = 0;
  int                   stall_pct = 0;
  logic                 hold_on = 1'b0;
  event                 hold_go;

  logic [TS_W-1:0]      stamp_now = '0;
  logic [31:0]          nominal = 32'd42;

  int                   starts_seen = 0;
  int                   early_seen = 0;
  int                   kept_seen = 0;
  int                   outliers_seen = 0;
  int                   latches_seen = 0;
  int                   settings_used = 1;

  function automatic fia_out_t predict_timer(fia_in_t ev);
    logic [TS_W-1:0] delta;
    logic [31:0]     span;
    logic [31:0]     dev;
    logic [WIN_W:0]  win_sum;
    fia_out_t        r;
    r = '0;
    if (ev.kind == KIND_START) begin
      prev_stamp = ev.timestamp;
      starts_seen++;
    end else begin
      delta = ev.timestamp - prev_stamp;
      span = (delta > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : delta[31:0];
      r.elapsed_ticks = span;
      if (cur_min != 0 && span < cur_min) begin
        early_seen++;
      end else begin
        prev_stamp = ev.timestamp;
        r.frame_done = 1'b1;
        dev = (span >= mean_ticks) ? span - mean_ticks : mean_ticks - span;
        if (dev < cur_tps) begin
          if (ring_fill >= DEPTH) ring_total = ring_total - ring[ring_ptr];
          else ring_fill = ring_fill + 1'b1;
          ring[ring_ptr] = span;
          ring_total = ring_total + span;
          ring_ptr = (ring_ptr + 1) % DEPTH;
          kept_seen++;
        end else begin
          outliers_seen++;
        end
        if (win_frames != 16'hFFFF) win_frames = win_frames + 1'b1;
        win_sum = win_accum + span;
        win_accum = (win_sum > {1'b0, {WIN_W{1'b1}}}) ? {WIN_W{1'b1}} : win_sum[WIN_W-1:0];
        if (win_accum > cur_tps) begin
          rate_shown = win_frames;
          win_frames = '0;
          win_accum = '0;
          latches_seen++;
        end
        mean_ticks = (ring_fill != 0) ? ring_total / ring_fill : '0;
      end
    end
    r.average_ticks = mean_ticks;
    r.frame_rate = rate_shown;
    r.sample_count = ring_fill;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // result side: compare every accepted transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    fia_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %p", out_data_o));
      end else begin
        want = expected_q.pop_front();
        check_field("frame_done", out_data_o.frame_done, want.frame_done);
        check_field("elapsed_ticks", out_data_o.elapsed_ticks, want.elapsed_ticks);
        check_field("average_ticks", out_data_o.average_ticks, want.average_ticks);
        check_field("frame_rate", out_data_o.frame_rate, want.frame_rate);
        check_field("sample_count", out_data_o.sample_count, want.sample_count);
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    forever begin
      @(hold_go);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_event(fia_in_t ev, bit typed, fia_out_t want);
    fia_out_t predicted;
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_timer(ev);
    expected_q.push_back(typed ? want : predicted);
  endtask

  task automatic sender_gap();
    int n;
    if ($urandom_range(0, 99) < send_pct) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50) : $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_config(logic [31:0] tps, logic [31:0] mft);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_TICKS_PER_SECOND;
    cfg_data_i <= tps;
    @(posedge clk_i);
    cfg_idx_i <= REG_MIN_FRAME_TICKS;
    cfg_data_i <= mft;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_tps = tps;
    cur_min = mft;
    nominal = tps / 24 + 1;
    settings_used++;
  endtask

  function automatic void add_event(logic kind, logic [63:0] ts, bit typed, fia_out_t want);
    dir_row_t row;
    row.what = ROW_EVENT;
    row.ev.kind = kind;
    row.ev.timestamp = ts;
    row.typed = typed;
    row.want = want;
    row.tps = '0;
    row.mft = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_config(logic [31:0] tps, logic [31:0] mft);
    dir_row_t row;
    row = '{ROW_CONFIG, '0, 1'b0, '0, tps, mft};
    dir_rows.push_back(row);
  endfunction

  // mostly regular frame spacing around the nominal interval, plus the odd cases
  function automatic fia_in_t next_timing_event();
    int      roll;
    fia_in_t ev;
    roll = $urandom_range(0, 99);
    ev.kind = KIND_FRAME;
    if (roll < 6) begin
      ev.kind = KIND_START;
    end else if (roll < 9) begin
      ev.kind = KIND_START;
      stamp_now = {$urandom, $urandom};
    end else if (roll < 75) begin
      stamp_now = stamp_now + (nominal - nominal / 4 + $urandom_range(0, nominal / 2));
    end else if (roll < 85) begin
      stamp_now = stamp_now + $urandom_range(0, nominal);
    end else if (roll < 91) begin
      stamp_now = stamp_now + nominal + cur_tps + $urandom_range(0, 1000);
    end else if (roll < 94) begin
      ev.timestamp = stamp_now - $urandom_range(1, 5000);
      return ev;
    end else if (roll < 97) begin
      stamp_now = stamp_now + {$urandom_range(1, 3), $urandom};
    end else begin
      stamp_now = {$urandom, $urandom};
    end
    ev.timestamp = stamp_now;
    return ev;
  endfunction

  initial begin
    phase_t plan[8];
    fia_in_t ev;
    logic [31:0] mft;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset settings first
    add_event(KIND_START, 64'd0, 1'b1, '0);
    add_event(KIND_FRAME, 64'd100, 1'b1, '{1'b1, 32'd100, 32'd100, 16'd0, 6'd1});
    add_event(KIND_FRAME, 64'd200, 1'b1, '{1'b1, 32'd100, 32'd100, 16'd0, 6'd2});
    // outlier by exactly one second, closes the rate window at three frames
    add_event(KIND_FRAME, 64'd1300, 1'b1, '{1'b1, 32'd1100, 32'd100, 16'd3, 6'd2});
    add_event(KIND_FRAME, 64'd1300, 1'b0, '0);
    // time going backward saturates
    add_event(KIND_FRAME, 64'd5, 1'b0, '0);
    add_event(KIND_START, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, '0);
    add_event(KIND_FRAME, 64'h0000_0000_0000_0010, 1'b0, '0);
    add_event(KIND_START, 64'd0, 1'b0, '0);
    add_event(KIND_FRAME, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
    add_event(KIND_START, 64'h0000_0001_0000_0000, 1'b0, '0);
    add_event(KIND_FRAME, 64'h0000_0001_FFFF_FFFE, 1'b0, '0);
    // frame lock: early frames are refused and retried
    add_config(32'd1000, 32'd500);
    add_event(KIND_START, 64'd10000, 1'b0, '0);
    add_event(KIND_FRAME, 64'd10200, 1'b0, '0);
    add_event(KIND_FRAME, 64'd10499, 1'b0, '0);
    add_event(KIND_FRAME, 64'd10500, 1'b0, '0);
    add_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_event(KIND_FRAME, 64'd10600, 1'b0, '0);
    add_event(KIND_FRAME, 64'd10500, 1'b0, '0);
    // zero second: nothing passes the outlier test
    add_config(32'd0, 32'd0);
    add_event(KIND_FRAME, 64'd10550, 1'b0, '0);
    add_event(KIND_FRAME, 64'd10550, 1'b0, '0);
    add_event(KIND_FRAME, 64'd10557, 1'b0, '0);
    add_config(TPS_RESET, 32'd0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].what == ROW_CONFIG) write_config(dir_rows[i].tps, dir_rows[i].mft);
      else send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
    end
    stamp_now = 64'd20000;

    plan[0] = '{32'd1000,      32'd0,         1'b0, 0,  0,  260, 1'b0, 1'b0};
    plan[1] = '{32'hFFFF_FFFF, 32'd0,         1'b0, 48, 0,  220, 1'b0, 1'b0};
    plan[2] = '{32'd24000,     32'd1000,      1'b0, 0,  48, 220, 1'b1, 1'b0};
    plan[3] = '{$urandom,      32'd0,         1'b0, 29, 29, 220, 1'b0, 1'b1};
    plan[4] = '{32'd1,         32'd1,         1'b0, 0,  0,  150, 1'b0, 1'b0};
    plan[5] = '{32'd2400,      32'hFFFF_FFFF, 1'b0, 48, 48, 80,  1'b0, 1'b0};
    plan[6] = '{$urandom,      32'd0,         1'b1, 0,  48, 220, 1'b0, 1'b0};
    plan[7] = '{TPS_RESET,     32'd0,         1'b0, 29, 29, 180, 1'b0, 1'b1};

    foreach (plan[p]) begin
      mft = plan[p].mft;
      if (plan[p].lock_near) mft = $urandom_range(1, plan[p].tps / 24 + 1);
      write_config(plan[p].tps, mft);
      send_pct = plan[p].send_pct;
      stall_pct = plan[p].stall_pct;
      if (plan[p].hold) -> hold_go;
      for (int n = 0; n < plan[p].events; n++) begin
        if (plan[p].pause && n == plan[p].events / 2) drain_results();
        ev = next_timing_event();
        send_event(ev, 1'b0, '0);
        sender_gap();
      end
    end

    drain_results();
    send_pct = 0;
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d starts, %0d frames kept, %0d outliers, %0d early under lock",
             starts_seen, kept_seen, outliers_seen, early_seen);
    $display("  %0d rate windows closed across %0d register settings, %0d cycles",
             latches_seen, settings_used, cycle_count);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
